// File: hw/rtl/moie_pkg.sv
// shared types, opcodes and micro-step table for the memory operand executor
// no dependencies; used by moie_div and memory_operand_instruction_executor
package moie_pkg;

  localparam int unsigned MEM_WORDS_DEF = 512;

  // opcodes
  localparam logic [5:0] OP_CONST  = 6'd0;
  localparam logic [5:0] OP_ISTORE = 6'd1;
  localparam logic [5:0] OP_ILOAD  = 6'd2;
  localparam logic [5:0] OP_COPY   = 6'd3;
  localparam logic [5:0] OP_ADD    = 6'd4;
  localparam logic [5:0] OP_SUB    = 6'd5;
  localparam logic [5:0] OP_MUL    = 6'd6;
  localparam logic [5:0] OP_DIV    = 6'd7;
  localparam logic [5:0] OP_MOD    = 6'd8;
  localparam logic [5:0] OP_EQ     = 6'd9;
  localparam logic [5:0] OP_GT     = 6'd10;
  localparam logic [5:0] OP_LT     = 6'd11;
  localparam logic [5:0] OP_LAND   = 6'd12;
  localparam logic [5:0] OP_LOR    = 6'd13;
  localparam logic [5:0] OP_LNOT   = 6'd14;
  localparam logic [5:0] OP_EMIT   = 6'd50;
  localparam logic [5:0] OP_INPUT  = 6'd60;

  typedef enum logic [2:0] {
    U_NOP, U_WRAP, U_READ, U_ALU, U_WRITE, U_EMIT
  } ukind_t;

  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_YT, SRC_XT, SRC_A, SRC_R, SRC_IV
  } usrc_t;

  typedef enum logic [1:0] {
    DST_A, DST_B, DST_T
  } udst_t;

  typedef struct packed {
    ukind_t kind;
    usrc_t  src;
    udst_t  dst;
  } uop_t;

  typedef struct packed {
    logic start;
    logic sgn;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic uop_t mk(input ukind_t k, input usrc_t s, input udst_t d);
    uop_t u;
    u.kind = k;
    u.src  = s;
    u.dst  = d;
    return u;
  endfunction

  // micro-step list of each opcode; write, emit and nop end the request
  function automatic uop_t uop_at(input logic [5:0] op, input logic [2:0] pc);
    uop_t u;
    u = mk(U_NOP, SRC_X, DST_A);
    unique case (op)
      OP_CONST: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd1: u = mk(U_WRITE, SRC_X, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_ISTORE: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_T);
          3'd2: u = mk(U_WRAP, SRC_X, DST_A);
          3'd3: u = mk(U_READ, SRC_X, DST_A);
          3'd4: u = mk(U_WRAP, SRC_YT, DST_A);
          3'd5: u = mk(U_WRITE, SRC_A, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_ILOAD: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_Y, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_T);
          3'd2: u = mk(U_WRAP, SRC_XT, DST_A);
          3'd3: u = mk(U_READ, SRC_X, DST_A);
          3'd4: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd5: u = mk(U_WRITE, SRC_A, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_COPY: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_X, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_A);
          3'd2: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd3: u = mk(U_WRITE, SRC_A, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_EQ, OP_GT, OP_LT, OP_LAND, OP_LOR: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_X, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_A);
          3'd2: u = mk(U_WRAP, SRC_Y, DST_A);
          3'd3: u = mk(U_READ, SRC_X, DST_B);
          3'd4: u = mk(U_ALU, SRC_X, DST_A);
          3'd5: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd6: u = mk(U_WRITE, SRC_R, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_LNOT: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_X, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_A);
          3'd2: u = mk(U_ALU, SRC_X, DST_A);
          3'd3: u = mk(U_WRAP, SRC_Z, DST_A);
          3'd4: u = mk(U_WRITE, SRC_R, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_EMIT: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_X, DST_A);
          3'd1: u = mk(U_READ, SRC_X, DST_A);
          3'd2: u = mk(U_EMIT, SRC_A, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      OP_INPUT: begin
        unique case (pc)
          3'd0: u = mk(U_WRAP, SRC_X, DST_A);
          3'd1: u = mk(U_WRITE, SRC_IV, DST_A);
          default: u = mk(U_NOP, SRC_X, DST_A);
        endcase
      end
      default: u = mk(U_NOP, SRC_X, DST_A);
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/moie_div.sv
// radix-2 restoring divider, signed or unsigned, one quotient bit per cycle
// depends on moie_pkg for the request and status structs
module moie_div (
  input  logic                 clk,
  input  logic                 rst,
  input  moie_pkg::div_req_t   req,
  input  logic [31:0]          dividend,
  input  logic [31:0]          divisor,
  output moie_pkg::div_status_t stat,
  output logic [31:0]          quot,
  output logic [31:0]          rem
);
  import moie_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_RUN  = 4'b0010,
    D_FIX  = 4'b0100,
    D_DONE = 4'b1000
  } dstate_t;

  dstate_t     state;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] d;
  logic [4:0]  cnt;
  logic        neg_q;
  logic        neg_r;
  logic        dzero;

  logic [32:0] r_sh;
  logic        fits;

  assign r_sh = {r, q[31]};
  assign fits = r_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg_q <= req.sgn & (dividend[31] ^ divisor[31]);
            neg_r <= req.sgn & dividend[31];
            dzero <= (divisor == '0);
            q     <= (req.sgn && dividend[31]) ? -dividend : dividend;
            d     <= (req.sgn && divisor[31]) ? -divisor : divisor;
            r     <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            r <= 32'(r_sh - {1'b0, d});
            q <= {q[30:0], 1'b1};
          end else begin
            r <= r_sh[31:0];
            q <= {q[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= D_FIX;
        end
        D_FIX: begin
          // zero divisor gives zero quotient and remainder
          if (dzero) begin
            q <= '0;
            r <= '0;
          end else begin
            q <= neg_q ? -q : q;
            r <= neg_r ? -r : r;
          end
          state <= D_DONE;
        end
        D_DONE: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != D_IDLE);
  assign stat.done = (state == D_DONE);
  assign quot = q;
  assign rem  = r;

endmodule

// File: hw/rtl/memory_operand_instruction_executor.sv
// memory-to-memory instruction executor: word store, micro-step sequencer, alu
// depends on moie_pkg and instantiates moie_div
//
// usage
//   s_* carries one instruction request (op, x, y, z, in_value); m_* carries the
//   emitted word of an emit instruction. all other opcodes give no result.
//   s_tready is high only while the sequencer is idle; one request is worked
//   at a time, stepping through a short list of micro-steps (address reduce,
//   store read, alu, store write or emit).
// paths
//   a store read goes through a registered read and a wait state; an address reduce
//   is a plain bit select when MEM_WORDS is a power of two, else it goes through the
//   shared divider, which also serves divide and modulo and sets the long path.
// reset
//   rst is synchronous; afterwards a clearing pass writes zero to every word,
//   and no request is taken until it ends.
// stall
//   the result sits in an output register; an emit waits only if that register
//   still holds a word not yet taken, other instructions never wait on m_tready.
module memory_operand_instruction_executor #(
  parameter int unsigned MEM_WORDS = moie_pkg::MEM_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: op[5:0], x[37:6], y[69:38], z[78:70],
  // in_value[110:79], zero pad[111]
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: out_value[31:0]
  output logic [31:0]  m_tdata
);
  import moie_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_WORDS);
  localparam bit          POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_DIV    = 5'b01000,
    S_RDWAIT = 5'b10000
  } state_t;

  state_t state;

  // latched request
  logic [5:0]  op_q;
  logic [31:0] x_q;
  logic [31:0] y_q;
  logic [8:0]  z_q;
  logic [31:0] iv_q;

  // sequencer position and working registers
  logic [2:0]    pc;
  logic [AW-1:0] addr;
  logic [AW-1:0] clr_addr;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   t;
  logic [31:0]   r;
  uop_t          cur;

  // word store
  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   rd_data;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  // shared divider
  div_req_t    div_req;
  div_status_t div_stat;
  logic [31:0] div_dd;
  logic [31:0] div_dv;
  logic [31:0] div_quot;
  logic [31:0] div_rem;

  logic [31:0] wrap_val;
  logic [31:0] alu_r;
  logic        is_div;
  logic        emit_fire;

  assign cur      = uop_at(op_q, pc);
  assign s_tready = (state == S_IDLE);
  assign is_div   = (op_q == OP_DIV) || (op_q == OP_MOD);

  // emit step loads the output register once it is free or being emptied
  assign emit_fire = (state == S_FETCH) && (cur.kind == U_EMIT) && (!m_tvalid || m_tready);

  // address source before reduction
  always_comb begin
    unique case (cur.src)
      SRC_X:   wrap_val = x_q;
      SRC_Y:   wrap_val = y_q;
      SRC_Z:   wrap_val = {23'b0, z_q};
      SRC_YT:  wrap_val = y_q + t;
      SRC_XT:  wrap_val = x_q + t;
      default: wrap_val = '0;
    endcase
  end

  // combinational alu, divide and modulo go to the divider
  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_r = a + b;
      OP_SUB:  alu_r = a - b;
      OP_MUL:  alu_r = a * b;
      OP_EQ:   alu_r = {31'b0, a == b};
      OP_GT:   alu_r = {31'b0, $signed(a) > $signed(b)};
      OP_LT:   alu_r = {31'b0, $signed(a) < $signed(b)};
      OP_LAND: alu_r = {31'b0, (a != '0) && (b != '0)};
      OP_LOR:  alu_r = {31'b0, (a != '0) || (b != '0)};
      OP_LNOT: alu_r = {31'b0, a == '0};
      default: alu_r = '0;
    endcase
  end

  // write port: clearing pass or a write micro-step
  always_comb begin
    we = (state == S_CLEAR) || ((state == S_FETCH) && (cur.kind == U_WRITE));
    wa = (state == S_CLEAR) ? clr_addr : addr;
    if (state == S_CLEAR) begin
      wd = '0;
    end else begin
      unique case (cur.src)
        SRC_X:   wd = x_q;
        SRC_A:   wd = a;
        SRC_R:   wd = r;
        SRC_IV:  wd = iv_q;
        default: wd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[addr];
  end

  // divider used for address reduction and for divide/modulo
  always_comb begin
    div_req.start = 1'b0;
    div_req.sgn   = (cur.kind == U_ALU);
    if (state == S_FETCH) begin
      div_req.start = ((cur.kind == U_WRAP) && !POW2) || ((cur.kind == U_ALU) && is_div);
    end
    div_dd = (cur.kind == U_WRAP) ? wrap_val : a;
    div_dv = (cur.kind == U_WRAP) ? 32'(MEM_WORDS) : b;
  end

  moie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dd),
    .divisor  (div_dv),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pc       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_fire) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_q  <= s_tdata[5:0];
            x_q   <= s_tdata[37:6];
            y_q   <= s_tdata[69:38];
            z_q   <= s_tdata[78:70];
            iv_q  <= s_tdata[110:79];
            pc    <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          unique case (cur.kind)
            U_NOP:   state <= S_IDLE;
            U_WRAP: begin
              if (POW2) begin
                addr <= wrap_val[AW-1:0];
                pc   <= pc + 3'd1;
              end else begin
                state <= S_DIV;
              end
            end
            U_READ:  state <= S_RDWAIT;
            U_ALU: begin
              if (is_div) begin
                state <= S_DIV;
              end else begin
                r  <= alu_r;
                pc <= pc + 3'd1;
              end
            end
            U_WRITE: state <= S_IDLE;
            U_EMIT: begin
              // hold here while the output register is still occupied
              if (emit_fire) begin
                m_tdata <= a;
                state   <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (cur.kind == U_WRAP) addr <= div_rem[AW-1:0];
            else r <= (op_q == OP_DIV) ? div_quot : div_rem;
            pc    <= pc + 3'd1;
            state <= S_FETCH;
          end
        end
        S_RDWAIT: begin
          unique case (cur.dst)
            DST_A:   a <= rd_data;
            DST_B:   b <= rd_data;
            DST_T:   t <= rd_data;
            default: a <= rd_data;
          endcase
          pc    <= pc + 3'd1;
          state <= S_FETCH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only ever comes from an emit instruction
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (op_q == OP_EMIT))
    else $error("result raised for a non-emit instruction");

  // one request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // the divider is never restarted while busy
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // nothing writes the store with data other than zero during the clearing pass
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (we && (wd == '0) && !s_tready))
    else $error("clearing pass disturbed");

endmodule

// File: test/testbench.sv
// self-checking bench for memory_operand_instruction_executor: directed table, then random requests
// keeps a mirror of the word store to predict every emitted word; depends on moie_pkg and the rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import moie_pkg::*;

  localparam int unsigned WORDS = MEM_WORDS_DEF;
  localparam int RANDOM_ITEMS = 2000;   // random requests with a known opcode
  localparam int CYCLE_LIMIT = 1000000; // hard stop, far above the slowest correct run
  localparam int DRAIN_LIMIT = 20000;   // bound on waiting for the last results
  localparam int SETTLE_CYCLES = 100;   // settle time after the drain, enough to cover the tail of a divide
  localparam int MAX_PRINTED = 40;

  // one instruction request, same field order as the s_tdata packing
  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [8:0]  z;
    logic [31:0] iv;
  } instr_t;

  // directed row: request plus an optional hand-typed emitted word
  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [8:0]  z;
    logic [31:0] iv;
    logic        typed;
    logic [31:0] word;
  } dir_row_t;

  typedef enum logic [1:0] {
    READY_ON, READY_OFF, READY_COIN
  } ready_mode_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // s_tdata from bit 0: op, x, y, z, in_value, zero pad
  logic [111:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // m_tdata from bit 0: out_value
  logic [31:0]  m_tdata;

  logic [31:0] mirror_words [WORDS];   // predicted contents of the word store
  logic [31:0] pending_words [$];      // emitted words still to come, oldest first
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int ready_left = 0;
  ready_mode_t ready_mode = READY_ON;

  localparam int N_DIRECTED = 27;

  // directed requests; typed words are those readable straight off the opcode semantics
  dir_row_t directed_rows [N_DIRECTED] = '{
    // emit right after the clearing pass
    '{OP_EMIT,   32'd0,          32'd0,          9'd0,   32'd0,          1'b1, 32'h0000_0000},
    '{OP_CONST,  32'h7fff_ffff,  32'd0,          9'd1,   32'd0,          1'b0, 32'd0},
    '{OP_CONST,  32'h8000_0000,  32'd0,          9'd2,   32'd0,          1'b0, 32'd0},
    '{OP_CONST,  32'hffff_ffff,  32'd0,          9'd3,   32'd0,          1'b0, 32'd0},
    // input store with an address that wraps down to word 4
    '{OP_INPUT,  32'h8000_0004,  32'hffff_ffff,  9'd511, 32'ha5a5_5a5a,  1'b0, 32'd0},
    '{OP_EMIT,   32'd4,          32'd0,          9'd0,   32'd0,          1'b1, 32'ha5a5_5a5a},
    // add overflow: max plus max
    '{OP_ADD,    32'd1,          32'd1,          9'd5,   32'd0,          1'b0, 32'd0},
    // most negative by minus one
    '{OP_DIV,    32'd2,          32'd3,          9'd6,   32'd0,          1'b0, 32'd0},
    '{OP_MOD,    32'd2,          32'd3,          9'd7,   32'd0,          1'b0, 32'd0},
    // divide and modulo by a zero word
    '{OP_DIV,    32'd1,          32'd0,          9'd8,   32'd0,          1'b0, 32'd0},
    '{OP_MOD,    32'd1,          32'd0,          9'd9,   32'd0,          1'b0, 32'd0},
    '{OP_EMIT,   32'd6,          32'd0,          9'd0,   32'd0,          1'b1, 32'h8000_0000},
    '{OP_EMIT,   32'd9,          32'd0,          9'd0,   32'd0,          1'b1, 32'h0000_0000},
    '{OP_SUB,    32'd2,          32'd1,          9'd10,  32'd0,          1'b0, 32'd0},
    '{OP_MUL,    32'd1,          32'd3,          9'd11,  32'd0,          1'b0, 32'd0},
    '{OP_EQ,     32'd3,          32'd3,          9'd12,  32'd0,          1'b0, 32'd0},
    '{OP_GT,     32'd1,          32'd2,          9'd13,  32'd0,          1'b0, 32'd0},
    '{OP_LT,     32'd2,          32'd1,          9'd14,  32'd0,          1'b0, 32'd0},
    '{OP_LAND,   32'd1,          32'd0,          9'd15,  32'd0,          1'b0, 32'd0},
    '{OP_LOR,    32'd0,          32'd3,          9'd16,  32'd0,          1'b0, 32'd0},
    '{OP_LNOT,   32'd0,          32'd0,          9'd17,  32'd0,          1'b0, 32'd0},
    // remainder keeps the sign of the dividend: min mod max
    '{OP_MOD,    32'd2,          32'd1,          9'd21,  32'd0,          1'b0, 32'd0},
    '{OP_COPY,   32'd1,          32'd0,          9'd511, 32'd0,          1'b0, 32'd0},
    // base plus index wraps past the top of the 32-bit range
    '{OP_ISTORE, 32'd5,          32'hffff_ffff,  9'd12,  32'd0,          1'b0, 32'd0},
    '{OP_ILOAD,  32'h7fff_ffff,  32'd12,         9'd20,  32'd0,          1'b0, 32'd0},
    // unknown opcode with every field at its top
    '{6'h3f,     32'hffff_ffff,  32'hffff_ffff,  9'h1ff, 32'hffff_ffff,  1'b0, 32'd0},
    '{OP_EMIT,   32'd20,         32'd0,          9'd0,   32'd0,          1'b0, 32'd0}
  };

  memory_operand_instruction_executor #(
    .MEM_WORDS(WORDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // any address, even a computed base plus index, is reduced modulo the store size
  function automatic logic [31:0] fold(input logic [31:0] a);
    return a % WORDS;
  endfunction

  // applies one instruction to the mirror; returns 1 with the word for an emit
  function automatic bit step_mirror(input instr_t ins, output logic [31:0] word);
    logic [31:0] a, b, r;
    longint sa, sb;
    word = '0;
    r = '0;
    a = mirror_words[fold(ins.x)];
    b = mirror_words[fold(ins.y)];
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (ins.op)
      OP_CONST:  mirror_words[fold(ins.z)] = ins.x;
      OP_ISTORE: mirror_words[fold(ins.y + mirror_words[fold(ins.z)])] = a;
      OP_ILOAD:  mirror_words[fold(ins.z)] = mirror_words[fold(ins.x + b)];
      OP_COPY:   mirror_words[fold(ins.z)] = a;
      OP_ADD:    r = a + b;
      OP_SUB:    r = a - b;
      OP_MUL:    r = a * b;
      // 64-bit operands so most negative by minus one wraps instead of trapping
      OP_DIV:    r = (b == 0) ? '0 : 32'(sa / sb);
      OP_MOD:    r = (b == 0) ? '0 : 32'(sa % sb);
      OP_EQ:     r = {31'b0, a == b};
      OP_GT:     r = {31'b0, sa > sb};
      OP_LT:     r = {31'b0, sa < sb};
      OP_LAND:   r = {31'b0, (a != 0) && (b != 0)};
      OP_LOR:    r = {31'b0, (a != 0) || (b != 0)};
      OP_LNOT:   r = {31'b0, a == 0};
      OP_EMIT: begin
        word = a;
        return 1'b1;
      end
      OP_INPUT:  mirror_words[fold(ins.x)] = ins.iv;
      default: ;
    endcase
    if ((ins.op >= OP_ADD && ins.op <= OP_LOR) || ins.op == OP_LNOT)
      mirror_words[fold(ins.z)] = r;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
  endtask

  // mostly a few low words, often with junk above bit 8 so that wrapping is exercised
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      a[8:0] = 9'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 0)
        a[31:9] = '0;
    end
    return a;
  endfunction

  // data words weighted toward the edges of the signed range
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = 32'd1;
      2: w = '1;
      3: w = 32'h8000_0000;
      4: w = 32'h7fff_ffff;
      5: w = 32'($urandom_range(0, 16)) - 32'd8;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    int pick;
    ins.x = pick_addr();
    ins.y = pick_addr();
    ins.z = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 15));
    ins.iv = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      ins.op = OP_CONST;
      ins.x = pick_word();
    end else if (pick < 20) begin
      ins.op = OP_INPUT;
      ins.iv = pick_word();
    end else if (pick < 42) begin
      ins.op = OP_EMIT;
    end else if (pick < 80) begin
      ins.op = 6'($urandom_range(OP_ADD, OP_LOR));
    end else if (pick < 85) begin
      ins.op = OP_LNOT;
    end else if (pick < 89) begin
      ins.op = OP_COPY;
    end else if (pick < 93) begin
      ins.op = OP_ISTORE;
    end else if (pick < 97) begin
      ins.op = OP_ILOAD;
    end else begin
      // opcode with no meaning: the block must leave the store alone
      do ins.op = 6'($urandom_range(OP_LNOT + 1, 63));
      while (ins.op == OP_EMIT || ins.op == OP_INPUT);
    end
    return ins;
  endfunction

  // drive one request and hold it until the block takes it, then predict
  task automatic push_request(input instr_t ins, input bit typed, input logic [31:0] typed_word);
    logic [31:0] word;
    s_tdata  <= {1'b0, ins.iv, ins.z, ins.y, ins.x, ins.op};
    s_tvalid <= 1'b1;
    do @(posedge clk);
    while (!s_tready);
    if (step_mirror(ins, word))
      pending_words = {pending_words, (typed ? typed_word : word)};
  endtask

  // sender bursts: random length, random gap, now and then a long run with no gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  // sender goes quiet until every emitted word has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk);
    while (pending_words.size() != 0);
  endtask

  // receiver stall pattern: runs of ready, runs of stall, runs of coin flips
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_left = $urandom_range(1, 40);
    end
    ready_left = ready_left - 1;
    case (ready_mode)
      READY_ON:  m_tready <= 1'b1;
      READY_OFF: m_tready <= 1'b0;
      default:   m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // every accepted result is checked against the oldest predicted word
  always @(posedge clk) begin : watch_results
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result with no emit pending", m_tdata, '0);
      end else begin
        want = pending_words.pop_front();
        if (m_tdata !== want)
          report_mismatch("out_value", m_tdata, want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    instr_t ins;
    int counted;
    int drain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    foreach (mirror_words[i])
      mirror_words[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table; s_tready stays low through the clearing pass, so the
    // first request simply waits for it
    foreach (directed_rows[i]) begin
      ins = '{directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
              directed_rows[i].z, directed_rows[i].iv};
      pace_sender();
      push_request(ins, directed_rows[i].typed, directed_rows[i].word);
    end
    wait_for_results();

    // random part, unknown opcodes do not count toward the total
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      ins = random_instr();
      if (counted == RANDOM_ITEMS / 2)
        wait_for_results();
      pace_sender();
      push_request(ins, 1'b0, '0);
      if (ins.op <= OP_LNOT || ins.op == OP_EMIT || ins.op == OP_INPUT)
        counted++;
    end

    // drain, then give the block time to show any stray result
    s_tvalid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (pending_words.size() != 0 && drain < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("emitted words missing at end", '0, pending_words[0]);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/moie_pkg.sv
hw/rtl/moie_div.sv
hw/rtl/memory_operand_instruction_executor.sv
test/testbench.sv
